>>> design/dpdc_pkg.sv
// dpdc_pkg: shared constants, register map, configuration and command types
// for the differential drive pd controller. No dependencies.

package dpdc_pkg;

  // board constants
  localparam int unsigned PWM_FULL_SCALE = 10000;
  localparam int unsigned DEADZONE_LEFT  = 1200;
  localparam int unsigned DEADZONE_RIGHT = 1150;
  localparam int unsigned DUTY_LIMIT_PCT = 30;

  // fixed point constants, Q16.16 unless noted
  localparam int unsigned PWM_PER_PCT    = PWM_FULL_SCALE / 100;
  localparam int unsigned STEER_LIMIT    = 58982;
  localparam int unsigned COUNT_TO_SPEED = 231;
  localparam int unsigned TARGET_FLOOR   = 1311;
  localparam int unsigned TARGET_MAX     = 20'hFFFF0;
  localparam int unsigned DUTY_FLOOR     = 32768;
  localparam int unsigned DUTY_MAX       = DUTY_LIMIT_PCT * 65536;

  // widths
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned PADDR_W  = $clog2(NUM_REGS * 4);
  localparam int unsigned MA_W     = 25;
  localparam int unsigned MB_W     = 33;
  localparam int unsigned PROD_W   = MA_W + MB_W;
  localparam int unsigned ACC_W    = PROD_W;
  localparam int unsigned STEER_W  = 17;
  localparam int unsigned TGT_W    = 20;
  localparam int unsigned SPD_W    = 24;
  localparam int unsigned ERR_W    = 25;
  localparam int unsigned CMP_W    = 13;
  localparam int unsigned DUTY_W   = $clog2(DUTY_MAX + 1);
  localparam int unsigned PCT_W    = $clog2(PWM_PER_PCT + 1);
  localparam int unsigned COMPARE_MAX = (2 ** CMP_W) - 1;

  typedef enum logic [2:0] {
    REG_BASE_SPEED,
    REG_WHEEL_KP,
    REG_WHEEL_KD,
    REG_LEFT_FF,
    REG_RIGHT_FF,
    REG_STEER_LIN,
    REG_STEER_SQ,
    REG_STEER_KD
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] base_speed;
    logic [15:0] wheel_prop_gain;
    logic [15:0] wheel_deriv_gain;
    logic [15:0] left_feedforward;
    logic [15:0] right_feedforward;
    logic [23:0] steer_linear_gain;
    logic [23:0] steer_square_gain;
    logic [15:0] steer_deriv_gain;
  } cfg_t;

  // operand pair fed to the shared multiplier
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_E_ABS,
    MUL_LIN,
    MUL_SQ,
    MUL_DRV,
    MUL_LSPD,
    MUL_RSPD,
    MUL_KPL,
    MUL_KDL,
    MUL_FFL,
    MUL_KPR,
    MUL_KDR,
    MUL_FFR
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_SHL
  } acc_op_e;

  typedef struct packed {
    logic     load_in;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     save_eae;
    logic     save_steer;
    logic     save_spdl;
    logic     save_targets;
    logic     save_err;
    logic     save_duty_l;
    logic     save_cmp_l;
    logic     save_duty_r;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } dp_status_t;

endpackage

>>> design/differential_drive_pd_controller.sv
// differential_drive_pd_controller: top level of the steering and wheel pd
// controller. Depends on dpdc_pkg, dpdc_regs, dpdc_ctrl and dpdc_dp.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one control tick:
//   line_error_i, left_count_i, right_count_i. Output channel
//   (out_valid_o / out_stall_i) returns one result per tick: both PWM
//   compare values, the clamped steering term and both wheel targets.
//   A transaction moves at a clock edge with valid high and stall low.
//   Sequence: a tick is taken in the idle cycle, then the sequencer steps
//   one shared 25x33 multiplier through twelve products in turn; a new
//   tick is taken only after the previous one has left its last step.
//   An output register holds the finished result, so in_stall_o drops
//   again while the result waits; if out_stall_i still holds the previous
//   result when the next tick finishes, that tick waits in its last step.
//   The APB port writes the eight gain and speed registers at 4-byte steps
//   and should be used only while no tick is in flight.
//   Reset loads the register defaults, clears the stored line and wheel
//   errors and empties the output register.

module differential_drive_pd_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dpdc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [15:0]            line_error_i,
  input  logic signed [15:0]            left_count_i,
  input  logic signed [15:0]            right_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [12:0]                   left_compare_o,
  output logic [12:0]                   right_compare_o,
  output logic signed [12:0]            steer_out_o,
  output logic [15:0]                   left_target_o,
  output logic [15:0]                   right_target_o
);

  dpdc_pkg::cfg_t       cfg;
  dpdc_pkg::dp_cmd_t    cmd;
  dpdc_pkg::dp_status_t status;

  dpdc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dpdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dpdc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .status_o        (status),
    .line_error_i    (line_error_i),
    .left_count_i    (left_count_i),
    .right_count_i   (right_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .left_compare_o  (left_compare_o),
    .right_compare_o (right_compare_o),
    .steer_out_o     (steer_out_o),
    .left_target_o   (left_target_o),
    .right_target_o  (right_target_o)
  );

endmodule

>>> design/dpdc_regs.sv
// dpdc_regs: apb configuration register file of the pd controller.
// Depends on dpdc_pkg for the register map and the cfg_t bundle.

module dpdc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dpdc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output dpdc_pkg::cfg_t              cfg_o
);

  dpdc_pkg::cfg_t     cfg_q;
  dpdc_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = dpdc_pkg::reg_idx_e'(paddr[dpdc_pkg::PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_speed        <= 16'd4096;
      cfg_q.wheel_prop_gain   <= 16'd3584;
      cfg_q.wheel_deriv_gain  <= 16'd2048;
      cfg_q.left_feedforward  <= 16'd1152;
      cfg_q.right_feedforward <= 16'd1024;
      cfg_q.steer_linear_gain <= 24'd6711;
      cfg_q.steer_square_gain <= 24'd755;
      cfg_q.steer_deriv_gain  <= 16'd1843;
    end else if (wr_en) begin
      case (idx)
        dpdc_pkg::REG_BASE_SPEED: cfg_q.base_speed        <= pwdata[15:0];
        dpdc_pkg::REG_WHEEL_KP:   cfg_q.wheel_prop_gain   <= pwdata[15:0];
        dpdc_pkg::REG_WHEEL_KD:   cfg_q.wheel_deriv_gain  <= pwdata[15:0];
        dpdc_pkg::REG_LEFT_FF:    cfg_q.left_feedforward  <= pwdata[15:0];
        dpdc_pkg::REG_RIGHT_FF:   cfg_q.right_feedforward <= pwdata[15:0];
        dpdc_pkg::REG_STEER_LIN:  cfg_q.steer_linear_gain <= pwdata[23:0];
        dpdc_pkg::REG_STEER_SQ:   cfg_q.steer_square_gain <= pwdata[23:0];
        dpdc_pkg::REG_STEER_KD:   cfg_q.steer_deriv_gain  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dpdc_pkg::REG_BASE_SPEED: prdata = {16'b0, cfg_q.base_speed};
      dpdc_pkg::REG_WHEEL_KP:   prdata = {16'b0, cfg_q.wheel_prop_gain};
      dpdc_pkg::REG_WHEEL_KD:   prdata = {16'b0, cfg_q.wheel_deriv_gain};
      dpdc_pkg::REG_LEFT_FF:    prdata = {16'b0, cfg_q.left_feedforward};
      dpdc_pkg::REG_RIGHT_FF:   prdata = {16'b0, cfg_q.right_feedforward};
      dpdc_pkg::REG_STEER_LIN:  prdata = {8'b0, cfg_q.steer_linear_gain};
      dpdc_pkg::REG_STEER_SQ:   prdata = {8'b0, cfg_q.steer_square_gain};
      dpdc_pkg::REG_STEER_KD:   prdata = {16'b0, cfg_q.steer_deriv_gain};
      default:                  prdata = 32'b0;
    endcase
  end

endmodule

>>> design/dpdc_ctrl.sv
// dpdc_ctrl: sequencer of the pd controller; steps the shared multiplier
// and accumulator through one control tick. Depends on dpdc_pkg.

module dpdc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dpdc_pkg::dp_status_t status_i,
  output dpdc_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ABS,
    ST_LIN,
    ST_SQ,
    ST_DRV,
    ST_LSPD,
    ST_STEER,
    ST_TARGET,
    ST_ERR,
    ST_KPL,
    ST_KDL,
    ST_FFL,
    ST_KPR,
    ST_KDR,
    ST_FFR,
    ST_ACCR,
    ST_DUTYR,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = dpdc_pkg::MUL_NONE;
    cmd_o.acc_op  = dpdc_pkg::ACC_HOLD;
    state_d       = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_ABS;
        end
      end
      ST_ABS: begin
        cmd_o.mul_sel = dpdc_pkg::MUL_E_ABS;
        state_d       = ST_LIN;
      end
      ST_LIN: begin
        cmd_o.save_eae = 1'b1;
        cmd_o.mul_sel  = dpdc_pkg::MUL_LIN;
        state_d        = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.acc_op  = dpdc_pkg::ACC_LOAD;
        cmd_o.mul_sel = dpdc_pkg::MUL_SQ;
        state_d       = ST_DRV;
      end
      ST_DRV: begin
        cmd_o.acc_op  = dpdc_pkg::ACC_ADD;
        cmd_o.mul_sel = dpdc_pkg::MUL_DRV;
        state_d       = ST_LSPD;
      end
      ST_LSPD: begin
        // derivative term of the steering sum sits 12 bits up
        cmd_o.acc_op  = dpdc_pkg::ACC_ADD_SHL;
        cmd_o.mul_sel = dpdc_pkg::MUL_LSPD;
        state_d       = ST_STEER;
      end
      ST_STEER: begin
        cmd_o.save_steer = 1'b1;
        cmd_o.save_spdl  = 1'b1;
        cmd_o.mul_sel    = dpdc_pkg::MUL_RSPD;
        state_d          = ST_TARGET;
      end
      ST_TARGET: begin
        cmd_o.save_targets = 1'b1;
        state_d            = ST_ERR;
      end
      ST_ERR: begin
        cmd_o.save_err = 1'b1;
        state_d        = ST_KPL;
      end
      ST_KPL: begin
        cmd_o.mul_sel = dpdc_pkg::MUL_KPL;
        state_d       = ST_KDL;
      end
      ST_KDL: begin
        cmd_o.acc_op  = dpdc_pkg::ACC_LOAD;
        cmd_o.mul_sel = dpdc_pkg::MUL_KDL;
        state_d       = ST_FFL;
      end
      ST_FFL: begin
        cmd_o.acc_op  = dpdc_pkg::ACC_ADD;
        cmd_o.mul_sel = dpdc_pkg::MUL_FFL;
        state_d       = ST_KPR;
      end
      ST_KPR: begin
        cmd_o.acc_op  = dpdc_pkg::ACC_ADD;
        cmd_o.mul_sel = dpdc_pkg::MUL_KPR;
        state_d       = ST_KDR;
      end
      ST_KDR: begin
        // left sum is complete here, right sum starts over it
        cmd_o.save_duty_l = 1'b1;
        cmd_o.acc_op      = dpdc_pkg::ACC_LOAD;
        cmd_o.mul_sel     = dpdc_pkg::MUL_KDR;
        state_d           = ST_FFR;
      end
      ST_FFR: begin
        cmd_o.save_cmp_l = 1'b1;
        cmd_o.acc_op     = dpdc_pkg::ACC_ADD;
        cmd_o.mul_sel    = dpdc_pkg::MUL_FFR;
        state_d          = ST_ACCR;
      end
      ST_ACCR: begin
        cmd_o.acc_op = dpdc_pkg::ACC_ADD;
        state_d      = ST_DUTYR;
      end
      ST_DUTYR: begin
        cmd_o.save_duty_r = 1'b1;
        state_d           = ST_FINISH;
      end
      ST_FINISH: begin
        // wait here while the previous result is still held
        if (!status_i.out_blocked) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/dpdc_dp.sv
// dpdc_dp: datapath of the pd controller: shared multiplier, accumulator,
// clamps, wheel error memory and the output register. Depends on dpdc_pkg.

module dpdc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dpdc_pkg::cfg_t                      cfg_i,
  input  dpdc_pkg::dp_cmd_t                   cmd_i,
  output dpdc_pkg::dp_status_t                status_o,
  input  logic signed [15:0]                  line_error_i,
  input  logic signed [15:0]                  left_count_i,
  input  logic signed [15:0]                  right_count_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dpdc_pkg::CMP_W-1:0]          left_compare_o,
  output logic [dpdc_pkg::CMP_W-1:0]          right_compare_o,
  output logic signed [dpdc_pkg::CMP_W-1:0]   steer_out_o,
  output logic [15:0]                         left_target_o,
  output logic [15:0]                         right_target_o
);

  localparam int unsigned MA_W   = dpdc_pkg::MA_W;
  localparam int unsigned MB_W   = dpdc_pkg::MB_W;
  localparam int unsigned PROD_W = dpdc_pkg::PROD_W;
  localparam int unsigned ACC_W  = dpdc_pkg::ACC_W;
  localparam int unsigned SH_W   = ACC_W - 8;
  localparam int unsigned STEER_W = dpdc_pkg::STEER_W;
  localparam int unsigned TGT_W  = dpdc_pkg::TGT_W;
  localparam int unsigned SPD_W  = dpdc_pkg::SPD_W;
  localparam int unsigned ERR_W  = dpdc_pkg::ERR_W;
  localparam int unsigned DUTY_W = dpdc_pkg::DUTY_W;
  localparam int unsigned PCT_W  = dpdc_pkg::PCT_W;
  localparam int unsigned CMP_W  = dpdc_pkg::CMP_W;
  localparam int unsigned SCL_W  = DUTY_W + PCT_W;
  localparam int unsigned CNT_W  = SCL_W - 16;
  localparam int unsigned SUM_W  = ((CNT_W > CMP_W) ? CNT_W : CMP_W) + 1;
  localparam int unsigned TSUM_W = TGT_W + 2;

  localparam logic signed [SH_W-1:0] STEER_HI = SH_W'(dpdc_pkg::STEER_LIMIT);
  localparam logic signed [SH_W-1:0] STEER_LO = -STEER_HI;
  localparam logic signed [SH_W-1:0] DUTY_LO  = SH_W'(dpdc_pkg::DUTY_FLOOR);
  localparam logic signed [SH_W-1:0] DUTY_HI  = SH_W'(dpdc_pkg::DUTY_MAX);
  localparam logic signed [TSUM_W-1:0] TGT_LO = TSUM_W'(dpdc_pkg::TARGET_FLOOR);
  localparam logic signed [TSUM_W-1:0] TGT_HI = TSUM_W'(dpdc_pkg::TARGET_MAX);
  localparam logic [CMP_W-1:0] DZ_LEFT  = CMP_W'(dpdc_pkg::DEADZONE_LEFT);
  localparam logic [CMP_W-1:0] DZ_RIGHT = CMP_W'(dpdc_pkg::DEADZONE_RIGHT);

  // Q.24 sum >> 8 to Q16.16, clamped to the duty window (lower bound: floor)
  function automatic logic [DUTY_W-1:0] clamp_duty(input logic [ACC_W-1:0] sum);
    logic signed [SH_W-1:0] raw;
    raw = sum[ACC_W-1:8];
    if (raw < DUTY_LO) begin
      return DUTY_W'(dpdc_pkg::DUTY_FLOOR);
    end else if (raw > DUTY_HI) begin
      return DUTY_W'(dpdc_pkg::DUTY_MAX);
    end
    return raw[DUTY_W-1:0];
  endfunction

  function automatic logic [CMP_W-1:0] duty_to_compare(input logic [DUTY_W-1:0] duty,
                                                       input logic [CMP_W-1:0] dz);
    logic [SCL_W-1:0] scaled;
    logic [SUM_W-1:0] total;
    scaled = duty * PCT_W'(dpdc_pkg::PWM_PER_PCT);
    total  = SUM_W'(scaled[SCL_W-1:16]) + SUM_W'(dz);
    if (total > SUM_W'(dpdc_pkg::COMPARE_MAX)) begin
      return CMP_W'(dpdc_pkg::COMPARE_MAX);
    end
    return total[CMP_W-1:0];
  endfunction

  // captured transaction and working registers
  logic signed [15:0]        e_q, lc_q, rc_q;
  logic signed [15:0]        last_e_q;
  logic signed [31:0]        eae_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [STEER_W-1:0] steer_q;
  logic signed [SPD_W-1:0]   spdl_q;
  logic [TGT_W-1:0]          tl_q, tr_q;
  logic signed [ERR_W-1:0]   errl_q, errr_q;
  logic signed [ERR_W-1:0]   lastl_q, lastr_q;
  logic [DUTY_W-1:0]         dutyl_q, dutyr_q;
  logic [CMP_W-1:0]          cmpl_q;
  logic                      out_valid_q;
  logic [CMP_W-1:0]          left_cmp_q, right_cmp_q;
  logic signed [CMP_W-1:0]   steer_out_q;
  logic [15:0]               left_tgt_q, right_tgt_q;

  // operand selection
  logic signed [16:0]        e_ext, e_abs, de_line;
  logic signed [ERR_W:0]     de_left, de_right;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  assign e_ext    = 17'(e_q);
  assign e_abs    = e_q[15] ? -e_ext : e_ext;
  assign de_line  = e_ext - 17'(last_e_q);
  assign de_left  = (ERR_W + 1)'(errl_q) - (ERR_W + 1)'(lastl_q);
  assign de_right = (ERR_W + 1)'(errr_q) - (ERR_W + 1)'(lastr_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      dpdc_pkg::MUL_E_ABS: begin
        mul_a = MA_W'(e_q);
        mul_b = MB_W'(e_abs);
      end
      dpdc_pkg::MUL_LIN: begin
        mul_a = $signed({1'b0, cfg_i.steer_linear_gain});
        mul_b = MB_W'(e_q);
      end
      dpdc_pkg::MUL_SQ: begin
        mul_a = $signed({1'b0, cfg_i.steer_square_gain});
        mul_b = MB_W'(eae_q);
      end
      dpdc_pkg::MUL_DRV: begin
        mul_a = MA_W'($signed({1'b0, cfg_i.steer_deriv_gain}));
        mul_b = MB_W'(de_line);
      end
      dpdc_pkg::MUL_LSPD: begin
        mul_a = MA_W'(dpdc_pkg::COUNT_TO_SPEED);
        mul_b = MB_W'(lc_q);
      end
      dpdc_pkg::MUL_RSPD: begin
        mul_a = MA_W'(dpdc_pkg::COUNT_TO_SPEED);
        mul_b = MB_W'(rc_q);
      end
      dpdc_pkg::MUL_KPL: begin
        mul_a = MA_W'($signed({1'b0, cfg_i.wheel_prop_gain}));
        mul_b = MB_W'(errl_q);
      end
      dpdc_pkg::MUL_KDL: begin
        mul_a = MA_W'($signed({1'b0, cfg_i.wheel_deriv_gain}));
        mul_b = MB_W'(de_left);
      end
      dpdc_pkg::MUL_FFL: begin
        mul_a = MA_W'($signed({1'b0, cfg_i.left_feedforward}));
        mul_b = MB_W'($signed({1'b0, tl_q}));
      end
      dpdc_pkg::MUL_KPR: begin
        mul_a = MA_W'($signed({1'b0, cfg_i.wheel_prop_gain}));
        mul_b = MB_W'(errr_q);
      end
      dpdc_pkg::MUL_KDR: begin
        mul_a = MA_W'($signed({1'b0, cfg_i.wheel_deriv_gain}));
        mul_b = MB_W'(de_right);
      end
      dpdc_pkg::MUL_FFR: begin
        mul_a = MA_W'($signed({1'b0, cfg_i.right_feedforward}));
        mul_b = MB_W'($signed({1'b0, tr_q}));
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // steering clamp: Q.24 sum floored to Q16.16
  logic signed [SH_W-1:0]    steer_raw;
  logic signed [STEER_W-1:0] steer_d;

  assign steer_raw = acc_q[ACC_W-1:8];

  always_comb begin
    if (steer_raw > STEER_HI) begin
      steer_d = STEER_W'(STEER_HI);
    end else if (steer_raw < STEER_LO) begin
      steer_d = STEER_W'(STEER_LO);
    end else begin
      steer_d = steer_raw[STEER_W-1:0];
    end
  end

  // wheel targets: base minus / plus steer, floored and saturated
  logic signed [TSUM_W-1:0] base_ext, tl_raw, tr_raw;
  logic [TGT_W-1:0]         tl_d, tr_d;

  assign base_ext = $signed({2'b0, cfg_i.base_speed, 4'b0});
  assign tl_raw   = base_ext - TSUM_W'(steer_q);
  assign tr_raw   = base_ext + TSUM_W'(steer_q);

  always_comb begin
    if (tl_raw < TGT_LO) begin
      tl_d = TGT_W'(dpdc_pkg::TARGET_FLOOR);
    end else if (tl_raw > TGT_HI) begin
      tl_d = TGT_W'(dpdc_pkg::TARGET_MAX);
    end else begin
      tl_d = tl_raw[TGT_W-1:0];
    end
    if (tr_raw < TGT_LO) begin
      tr_d = TGT_W'(dpdc_pkg::TARGET_FLOOR);
    end else if (tr_raw > TGT_HI) begin
      tr_d = TGT_W'(dpdc_pkg::TARGET_MAX);
    end else begin
      tr_d = tr_raw[TGT_W-1:0];
    end
  end

  // state carried from tick to tick, plus the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_e_q    <= '0;
      lastl_q     <= '0;
      lastr_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.save_steer) begin
        last_e_q <= e_q;
      end
      if (cmd_i.load_out) begin
        lastl_q     <= errl_q;
        lastr_q     <= errr_q;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      e_q  <= line_error_i;
      lc_q <= left_count_i;
      rc_q <= right_count_i;
    end
    if (cmd_i.mul_sel != dpdc_pkg::MUL_NONE) begin
      prod_q <= mul_p;
    end
    case (cmd_i.acc_op)
      dpdc_pkg::ACC_LOAD:    acc_q <= prod_q;
      dpdc_pkg::ACC_ADD:     acc_q <= acc_q + prod_q;
      dpdc_pkg::ACC_ADD_SHL: acc_q <= acc_q + (prod_q <<< 12);
      default: ;
    endcase
    if (cmd_i.save_eae) begin
      eae_q <= prod_q[31:0];
    end
    if (cmd_i.save_steer) begin
      steer_q <= steer_d;
    end
    if (cmd_i.save_spdl) begin
      spdl_q <= prod_q[SPD_W-1:0];
    end
    if (cmd_i.save_targets) begin
      tl_q <= tl_d;
      tr_q <= tr_d;
    end
    if (cmd_i.save_err) begin
      // right speed product is still in the product register
      errl_q <= $signed({{(ERR_W - TGT_W){1'b0}}, tl_q}) - ERR_W'(spdl_q);
      errr_q <= $signed({{(ERR_W - TGT_W){1'b0}}, tr_q})
                - ERR_W'($signed(prod_q[SPD_W-1:0]));
    end
    if (cmd_i.save_duty_l) begin
      dutyl_q <= clamp_duty(acc_q);
    end
    if (cmd_i.save_cmp_l) begin
      cmpl_q <= duty_to_compare(dutyl_q, DZ_LEFT);
    end
    if (cmd_i.save_duty_r) begin
      dutyr_q <= clamp_duty(acc_q);
    end
    if (cmd_i.load_out) begin
      left_cmp_q  <= cmpl_q;
      right_cmp_q <= duty_to_compare(dutyr_q, DZ_RIGHT);
      steer_out_q <= steer_q[STEER_W-1:4];
      left_tgt_q  <= tl_q[TGT_W-1:4];
      right_tgt_q <= tr_q[TGT_W-1:4];
    end
  end

  assign status_o.out_blocked = out_valid_q & out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign left_compare_o  = left_cmp_q;
  assign right_compare_o = right_cmp_q;
  assign steer_out_o     = steer_out_q;
  assign left_target_o   = left_tgt_q;
  assign right_target_o  = right_tgt_q;

endmodule
